// ===== hdl/flink_pkg.sv =====
// shared types, constants and codes of the framed request/reply link
package flink_pkg;

    // receive frame length, from address byte to checksum byte
    localparam int FRAME_LEN  = 6;
    localparam int RX_CNT_W   = $clog2(FRAME_LEN);

    // reply frame: header, four data bytes, checksum
    localparam int REPLY_LEN  = 6;
    localparam int TX_CNT_W   = $clog2(REPLY_LEN);

    localparam logic [7:0] STATUS_HEADER  = 8'h11;
    localparam logic [7:0] MEASURE_HEADER = 8'h33;

    localparam logic [7:0] STATUS_CODE_RESET  = 8'd1;
    localparam logic [7:0] MEASURE_CODE_RESET = 8'd2;

    // fixed-point scaling of the measurement reply
    localparam int RAW_W        = 16;
    localparam int VAC_SCALE_W  = 13;
    localparam int IAC_SCALE_W  = 11;
    localparam logic [VAC_SCALE_W-1:0] VAC_SCALE = 13'd4973;
    localparam logic [IAC_SCALE_W-1:0] IAC_SCALE = 11'd1500;
    localparam int SCALE_SHIFT  = 15;
    localparam int VAC_PROD_W   = RAW_W + VAC_SCALE_W;
    localparam int IAC_PROD_W   = RAW_W + IAC_SCALE_W;
    localparam logic [15:0] STATE_MASK = 16'h00FF;

    // queue between front and back, and result buffer
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int OB_DEPTH    = 2;
    localparam int OB_PTR_W    = $clog2(OB_DEPTH);
    localparam int OB_CNT_W    = $clog2(OB_DEPTH + 1);

    // request kind bits
    localparam logic [1:0] KIND_NONE    = 2'b00;
    localparam logic [1:0] KIND_STATUS  = 2'b01;
    localparam logic [1:0] KIND_MEASURE = 2'b10;

    typedef enum logic
    {
        CMD_RX_BYTE = 1'b0,
        CMD_TX_SLOT = 1'b1
    } cmd_t;

    typedef enum logic
    {
        REG_STATUS_CODE  = 1'b0,
        REG_MEASURE_CODE = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        cmd_t        cmd;
        logic [7:0]  rx_byte;
        logic        rx_is_address;
        logic [1:0]  addr_kind;
        logic [15:0] fault_flags;
        logic [7:0]  pfc_state;
        logic [15:0] vac_scaled;
        logic [15:0] iac_scaled;
    } work_item_t;

    typedef struct packed
    {
        logic [7:0] tx_byte;
        logic       tx_is_address;
        logic       tx_last;
    } result_t;

endpackage

// ===== hdl/flink_front.sv =====
// front end: decodes the request code and scales the measurements
module flink_front
(
    input  logic                  command,
    input  logic [7:0]            rx_byte,
    input  logic                  rx_is_address,
    input  logic [15:0]           fault_flags,
    input  logic [7:0]            pfc_state,
    input  logic [15:0]           vac_rms_raw,
    input  logic [15:0]           iac_rms_raw,
    input  logic [7:0]            status_code,
    input  logic [7:0]            measure_code,
    output flink_pkg::work_item_t item
);
    import flink_pkg::*;

    logic [VAC_PROD_W-1:0] vac_prod;
    logic [IAC_PROD_W-1:0] iac_prod;
    logic [1:0]            kind;

    assign vac_prod = vac_rms_raw * VAC_SCALE;
    assign iac_prod = iac_rms_raw * IAC_SCALE;

    // status code wins when both codes match
    always_comb
    begin
        priority if (rx_byte == status_code)
        begin
            kind = KIND_STATUS;
        end
        else if (rx_byte == measure_code)
        begin
            kind = KIND_MEASURE;
        end
        else
        begin
            kind = KIND_NONE;
        end
    end

    always_comb
    begin
        item.cmd           = cmd_t'(command);
        item.rx_byte       = rx_byte;
        item.rx_is_address = rx_is_address;
        item.addr_kind     = kind;
        item.fault_flags   = fault_flags;
        item.pfc_state     = pfc_state;
        item.vac_scaled    = 16'(vac_prod >> SCALE_SHIFT);
        item.iac_scaled    = 16'(iac_prod >> SCALE_SHIFT);
    end

endmodule

// ===== hdl/flink_queue.sv =====
// short item queue between front and back
module flink_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  flink_pkg::work_item_t push_item,
    output logic                  full,
    input  logic                  pop,
    output flink_pkg::work_item_t head_item,
    output logic                  empty
);
    import flink_pkg::*;

    work_item_t           slot_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/flink_back.sv =====
// back end: receive framing, reply state, reply frames and result buffer
module flink_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  flink_pkg::work_item_t item,
    input  logic                  item_valid,
    output logic                  item_take,
    output flink_pkg::result_t    res,
    output logic                  empty,
    input  logic                  pop
);
    import flink_pkg::*;

    logic [RX_CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [1:0]          rx_kind_reg, rx_kind_next;
    logic [7:0]          rx_sum_reg, rx_sum_next;
    logic                reply_pending_reg, reply_pending_next;
    logic                reply_is_measure_reg, reply_is_measure_next;
    logic [TX_CNT_W-1:0] tx_count_reg, tx_count_next;
    logic [7:0]          status_frame_reg [1:REPLY_LEN-1];
    logic [7:0]          status_frame_next [1:REPLY_LEN-1];
    logic [7:0]          measure_frame_reg [1:REPLY_LEN-1];
    logic [7:0]          measure_frame_next [1:REPLY_LEN-1];

    result_t             ob_data_reg [OB_DEPTH];
    logic [OB_PTR_W-1:0] ob_wr_reg, ob_rd_reg;
    logic [OB_CNT_W-1:0] ob_count_reg, ob_count_next;

    logic                emit;
    logic                ob_pop;
    result_t             emit_res;
    logic [15:0]         word_a;
    logic [15:0]         word_b;
    logic [7:0]          header;
    logic [7:0]          byte_sum;
    logic [7:0]          frame_byte;

    assign item_take = item_valid && (ob_count_reg != OB_CNT_W'(OB_DEPTH));
    assign emit      = item_take && (item.cmd == CMD_TX_SLOT) && reply_pending_reg;
    assign empty     = (ob_count_reg == '0);
    assign ob_pop    = pop && !empty;
    assign res       = ob_data_reg[ob_rd_reg];

    // words and checksum of a rebuilt reply frame
    always_comb
    begin
        if (reply_is_measure_reg)
        begin
            word_a = item.vac_scaled;
            word_b = item.iac_scaled;
            header = MEASURE_HEADER;
        end
        else
        begin
            word_a = item.fault_flags;
            word_b = {8'h00, item.pfc_state} & STATE_MASK;
            header = STATUS_HEADER;
        end
        byte_sum = header + word_a[15:8] + word_a[7:0] + word_b[15:8] + word_b[7:0];
    end

    // receive side and reply progress on transmit slots
    always_comb
    begin
        rx_count_next         = rx_count_reg;
        rx_kind_next          = rx_kind_reg;
        rx_sum_next           = rx_sum_reg;
        reply_pending_next    = reply_pending_reg;
        reply_is_measure_next = reply_is_measure_reg;
        tx_count_next         = tx_count_reg;
        status_frame_next     = status_frame_reg;
        measure_frame_next    = measure_frame_reg;
        if (item_take)
        begin
            unique case (item.cmd)
                CMD_RX_BYTE:
                begin
                    if (item.rx_is_address)
                    begin
                        if (item.addr_kind != KIND_NONE)
                        begin
                            rx_kind_next  = rx_kind_reg | item.addr_kind;
                            rx_sum_next   = item.rx_byte;
                            rx_count_next = RX_CNT_W'(1);
                        end
                    end
                    else if (rx_kind_reg != KIND_NONE)
                    begin
                        if (rx_count_reg == RX_CNT_W'(FRAME_LEN - 1))
                        begin
                            if (item.rx_byte == ~rx_sum_reg)
                            begin
                                if (rx_kind_reg == KIND_STATUS)
                                begin
                                    reply_pending_next    = 1'b1;
                                    reply_is_measure_next = 1'b0;
                                end
                                else if (rx_kind_reg == KIND_MEASURE)
                                begin
                                    reply_pending_next    = 1'b1;
                                    reply_is_measure_next = 1'b1;
                                end
                            end
                            rx_count_next = '0;
                            rx_kind_next  = KIND_NONE;
                        end
                        else
                        begin
                            rx_sum_next   = rx_sum_reg + item.rx_byte;
                            rx_count_next = rx_count_reg + 1'b1;
                        end
                    end
                end
                CMD_TX_SLOT:
                begin
                    if (reply_pending_reg)
                    begin
                        if (tx_count_reg == '0)
                        begin
                            if (reply_is_measure_reg)
                            begin
                                measure_frame_next[1] = word_a[15:8];
                                measure_frame_next[2] = word_a[7:0];
                                measure_frame_next[3] = word_b[15:8];
                                measure_frame_next[4] = word_b[7:0];
                                measure_frame_next[5] = ~byte_sum;
                            end
                            else
                            begin
                                status_frame_next[1] = word_a[15:8];
                                status_frame_next[2] = word_a[7:0];
                                status_frame_next[3] = word_b[15:8];
                                status_frame_next[4] = word_b[7:0];
                                status_frame_next[5] = ~byte_sum;
                            end
                        end
                        if (tx_count_reg == TX_CNT_W'(REPLY_LEN - 1))
                        begin
                            tx_count_next      = '0;
                            reply_pending_next = 1'b0;
                        end
                        else
                        begin
                            tx_count_next = tx_count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // byte on offer for the current slot
    always_comb
    begin
        if (tx_count_reg == '0)
        begin
            frame_byte = reply_is_measure_reg ? MEASURE_HEADER : STATUS_HEADER;
        end
        else if (reply_is_measure_reg)
        begin
            frame_byte = measure_frame_reg[tx_count_reg];
        end
        else
        begin
            frame_byte = status_frame_reg[tx_count_reg];
        end
        emit_res.tx_byte       = frame_byte;
        emit_res.tx_is_address = (tx_count_reg == '0);
        emit_res.tx_last       = (tx_count_reg == TX_CNT_W'(REPLY_LEN - 1));
    end

    always_comb
    begin
        ob_count_next = ob_count_reg;
        if (emit && !ob_pop)
        begin
            ob_count_next = ob_count_reg + 1'b1;
        end
        else if (ob_pop && !emit)
        begin
            ob_count_next = ob_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg         <= '0;
            rx_kind_reg          <= KIND_NONE;
            rx_sum_reg           <= '0;
            reply_pending_reg    <= 1'b0;
            reply_is_measure_reg <= 1'b0;
            tx_count_reg         <= '0;
            status_frame_reg     <= '{default: 8'h00};
            measure_frame_reg    <= '{default: 8'h00};
            ob_wr_reg            <= '0;
            ob_rd_reg            <= '0;
            ob_count_reg         <= '0;
        end
        else
        begin
            rx_count_reg         <= rx_count_next;
            rx_kind_reg          <= rx_kind_next;
            rx_sum_reg           <= rx_sum_next;
            reply_pending_reg    <= reply_pending_next;
            reply_is_measure_reg <= reply_is_measure_next;
            tx_count_reg         <= tx_count_next;
            status_frame_reg     <= status_frame_next;
            measure_frame_reg    <= measure_frame_next;
            ob_count_reg         <= ob_count_next;
            if (emit)
            begin
                ob_wr_reg <= (ob_wr_reg == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : ob_wr_reg + 1'b1;
            end
            if (ob_pop)
            begin
                ob_rd_reg <= (ob_rd_reg == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : ob_rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ob_data_reg[ob_wr_reg] <= emit_res;
        end
    end

endmodule

// ===== hdl/framed_request_reply_link.sv =====
// top level of the framed request/reply link
//
// Framed request/reply link. Each input item is either a received byte
// (command 0, with its address mark) or an offered transmit slot (command 1).
// An address byte that matches the status or measurement request code opens a
// receive frame; the frame is complete on its sixth byte, and a correct
// checksum (low byte of the complement of the sum of the bytes before it) arms
// a reply. Each transmit slot while a reply is armed gives one result item:
// header 0x11 (status) or 0x33 (measurement), four data bytes, then a checksum;
// the first byte carries the address mark and the last one tx_last. The data
// is sampled from the item that opens a reply: fault word and state for a
// status reply, voltage scaled by 4973/32768 and current by 1500/32768 for a
// measurement reply. Throughput is one item per clock cycle, push and pop both
// sides, as long as results are popped and full stays low; an accepted item
// is registered in the four-entry queue between the decoding front end and
// the back end, which writes the result straight into the two-entry result
// buffer read by the result ports, and full rises only when that queue fills
// because results are not popped. The request codes sit in two 8-bit
// registers at byte addresses 0 and 4, read back over the same port; write
// them only while the link is idle. No clearing pass after reset.
module framed_request_reply_link
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [7:0]  rx_byte,
    input  logic        rx_is_address,
    input  logic [15:0] fault_flags,
    input  logic [7:0]  pfc_state,
    input  logic [15:0] vac_rms_raw,
    input  logic [15:0] iac_rms_raw,
    // result items
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  tx_byte,
    output logic        tx_is_address,
    output logic        tx_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import flink_pkg::*;

    logic [7:0] status_code_reg;
    logic [7:0] measure_code_reg;
    logic       cfg_write;
    reg_index_t cfg_index;

    work_item_t front_item;
    work_item_t head_item;
    logic       q_empty;
    logic       q_pop;
    result_t    res;

    // ---- register port: word aligned, index in address bit 2
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_code_reg  <= STATUS_CODE_RESET;
            measure_code_reg <= MEASURE_CODE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STATUS_CODE:  status_code_reg  <= pwdata[7:0];
                REG_MEASURE_CODE: measure_code_reg <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_STATUS_CODE:  prdata = {24'h000000, status_code_reg};
            REG_MEASURE_CODE: prdata = {24'h000000, measure_code_reg};
            default:          prdata = '0;
        endcase
    end

    // ---- front end: request decode and measurement scaling
    flink_front u_front
    (
        .command       (command),
        .rx_byte       (rx_byte),
        .rx_is_address (rx_is_address),
        .fault_flags   (fault_flags),
        .pfc_state     (pfc_state),
        .vac_rms_raw   (vac_rms_raw),
        .iac_rms_raw   (iac_rms_raw),
        .status_code   (status_code_reg),
        .measure_code  (measure_code_reg),
        .item          (front_item)
    );

    // ---- decoupling queue, its full flag is the input full
    flink_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    // ---- back end: framing, reply state and result buffer
    flink_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (head_item),
        .item_valid (!q_empty),
        .item_take  (q_pop),
        .res        (res),
        .empty      (empty),
        .pop        (pop)
    );

    assign tx_byte       = res.tx_byte;
    assign tx_is_address = res.tx_is_address;
    assign tx_last       = res.tx_last;

endmodule

// ===== hdl/flink_checker.sv =====
// port-level checks of the link, bound to the top level
module flink_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] tx_byte,
    input logic       tx_is_address,
    input logic       tx_last
);
    import flink_pkg::*;

    logic [TX_CNT_W-1:0] pos_reg;

    // position of the shown item within its reply frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (pop && !empty)
        begin
            pos_reg <= (pos_reg == TX_CNT_W'(REPLY_LEN - 1)) ? '0 : pos_reg + 1'b1;
        end
    end

    a_addr_mark: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (tx_is_address == (pos_reg == '0)))
        else $error("address mark out of frame position");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (tx_last == (pos_reg == TX_CNT_W'(REPLY_LEN - 1))))
        else $error("last mark out of frame position");

    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && tx_is_address) |-> (tx_byte == STATUS_HEADER || tx_byte == MEASURE_HEADER))
        else $error("bad reply header");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(tx_byte) && $stable(tx_last)))
        else $error("waiting item changed");

endmodule

bind framed_request_reply_link flink_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .tx_byte       (tx_byte),
    .tx_is_address (tx_is_address),
    .tx_last       (tx_last)
);

// ===== test/framed_request_reply_link_tb.sv =====
// testbench of the framed request/reply link: directed and random traffic checked by a predictor
`timescale 1ns / 100ps

module framed_request_reply_link_tb;

    import flink_pkg::*;

    localparam int CLK_HALF     = 6;
    // result path is the four-entry queue and the two-entry result buffer, so this covers any item in flight
    localparam int DRAIN_CYCLES = 12;
    // cycles with no item moving on either side before the run is declared hung
    localparam int STALL_LIMIT  = 1000;
    localparam int VAC_GAIN     = 4973;
    localparam int IAC_GAIN     = 1500;
    localparam int GAIN_SHIFT   = 15;

    // one input item as the testbench sees it
    typedef struct packed
    {
        cmd_t        cmd;
        logic [7:0]  rx_byte;
        logic        rx_addr;
        logic [15:0] fault;
        logic [7:0]  state;
        logic [15:0] vac;
        logic [15:0] iac;
    } link_event_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        command;
    logic [7:0]  rx_byte;
    logic        rx_is_address;
    logic [15:0] fault_flags;
    logic [7:0]  pfc_state;
    logic [15:0] vac_rms_raw;
    logic [15:0] iac_rms_raw;
    logic        empty;
    logic        pop;
    logic [7:0]  tx_byte;
    logic        tx_is_address;
    logic        tx_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state: request codes, receive side and both reply buffers
    logic [7:0]  status_code;
    logic [7:0]  measure_code;
    logic [4:0]  rx_fill;
    logic [1:0]  open_kinds;
    logic [7:0]  rx_buf [FRAME_LEN];
    logic        reply_armed;
    logic        reply_measure;
    logic [2:0]  tx_idx;
    logic [7:0]  reply_frames [2][REPLY_LEN];

    // reply bytes the link owes us, oldest first
    result_t     reply_bytes_due [$];

    int          error_count;
    int          quiet_cycles;
    int          sender_calm;
    bit          idling_on;

    framed_request_reply_link i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .rx_byte       (rx_byte),
        .rx_is_address (rx_is_address),
        .fault_flags   (fault_flags),
        .pfc_state     (pfc_state),
        .vac_rms_raw   (vac_rms_raw),
        .iac_rms_raw   (iac_rms_raw),
        .empty         (empty),
        .pop           (pop),
        .tx_byte       (tx_byte),
        .tx_is_address (tx_is_address),
        .tx_last       (tx_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void reset_link_model();
        status_code   = STATUS_CODE_RESET;
        measure_code  = MEASURE_CODE_RESET;
        rx_fill       = '0;
        open_kinds    = KIND_NONE;
        reply_armed   = 1'b0;
        reply_measure = 1'b0;
        tx_idx        = '0;
        foreach (rx_buf[k])
            rx_buf[k] = '0;
        foreach (reply_frames[s, k])
            reply_frames[s][k] = '0;
        reply_frames[0][0] = STATUS_HEADER;
        reply_frames[1][0] = MEASURE_HEADER;
    endfunction

    // receive side: address bytes open a frame, data bytes fill it, the last byte is the check
    function automatic void take_rx_byte(logic [7:0] b, logic is_addr);
        logic [1:0] kind;
        logic [7:0] sum;
        int         k;
        if (is_addr)
        begin
            // status wins when both codes match the same byte
            if (b == status_code)
                kind = KIND_STATUS;
            else if (b == measure_code)
                kind = KIND_MEASURE;
            else
                return;
            open_kinds = open_kinds | kind;
            rx_buf[0]  = b;
            rx_fill    = 5'd1;
            return;
        end
        if (open_kinds == KIND_NONE)
            return;
        if (rx_fill >= FRAME_LEN)
            rx_fill = '0;
        rx_buf[rx_fill] = b;
        rx_fill++;
        if (rx_fill < FRAME_LEN)
            return;
        sum = '0;
        for (k = 0; k < FRAME_LEN - 1; k++)
            sum += rx_buf[k];
        // a frame with both kinds open is dropped even with a good check byte
        if (rx_buf[FRAME_LEN - 1] == ~sum)
        begin
            if (open_kinds == KIND_STATUS)
            begin
                reply_armed   = 1'b1;
                reply_measure = 1'b0;
            end
            else if (open_kinds == KIND_MEASURE)
            begin
                reply_armed   = 1'b1;
                reply_measure = 1'b1;
            end
        end
        rx_fill    = '0;
        open_kinds = KIND_NONE;
    endfunction

    // one accepted item: update the state and queue the reply byte it causes, if any
    function automatic void predict_link_event(link_event_t e);
        logic [31:0] v_scaled;
        logic [31:0] i_scaled;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [7:0]  sum;
        result_t     r;
        int          k;
        if (e.cmd == CMD_RX_BYTE)
        begin
            take_rx_byte(e.rx_byte, e.rx_addr);
            return;
        end
        if (!reply_armed)
            return;
        if (tx_idx >= REPLY_LEN)
            tx_idx = '0;
        // the selected buffer is refreshed from this item only at the start of a reply
        if (tx_idx == 0)
        begin
            if (reply_measure)
            begin
                v_scaled = (32'(e.vac) * VAC_GAIN) >> GAIN_SHIFT;
                i_scaled = (32'(e.iac) * IAC_GAIN) >> GAIN_SHIFT;
                word_a   = v_scaled[15:0];
                word_b   = i_scaled[15:0];
            end
            else
            begin
                word_a = e.fault;
                word_b = {8'h00, e.state};
            end
            reply_frames[reply_measure][1] = word_a[15:8];
            reply_frames[reply_measure][2] = word_a[7:0];
            reply_frames[reply_measure][3] = word_b[15:8];
            reply_frames[reply_measure][4] = word_b[7:0];
            sum = '0;
            for (k = 0; k < REPLY_LEN - 1; k++)
                sum += reply_frames[reply_measure][k];
            reply_frames[reply_measure][REPLY_LEN - 1] = ~sum;
        end
        r.tx_byte       = reply_frames[reply_measure][tx_idx];
        r.tx_is_address = (tx_idx == 0);
        r.tx_last       = (tx_idx == REPLY_LEN - 1);
        reply_bytes_due.push_back(r);
        tx_idx++;
        if (tx_idx >= REPLY_LEN)
        begin
            tx_idx      = '0;
            reply_armed = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // item builders, biased towards the extremes of each field
    // ------------------------------------------------------------------

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic link_event_t random_event();
        link_event_t e;
        e.cmd     = cmd_t'($urandom_range(0, 1));
        e.rx_byte = pick_byte();
        e.rx_addr = 1'($urandom_range(0, 1));
        e.fault   = pick_word();
        e.state   = pick_byte();
        e.vac     = pick_word();
        e.iac     = pick_word();
        return e;
    endfunction

    function automatic link_event_t rx_event(logic [7:0] b, logic is_addr);
        link_event_t e;
        e         = random_event();
        e.cmd     = CMD_RX_BYTE;
        e.rx_byte = b;
        e.rx_addr = is_addr;
        return e;
    endfunction

    function automatic link_event_t slot_event();
        link_event_t e;
        e     = random_event();
        e.cmd = CMD_TX_SLOT;
        return e;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // present one item at the falling edge, hold it until a rising edge takes it
    task automatic send_link_event(link_event_t e);
        int gap;
        @(negedge clk);
        push          <= 1'b1;
        command       <= e.cmd;
        rx_byte       <= e.rx_byte;
        rx_is_address <= e.rx_addr;
        fault_flags   <= e.fault;
        pfc_state     <= e.state;
        vac_rms_raw   <= e.vac;
        iac_rms_raw   <= e.iac;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_link_event(e);
        // sender idling: short bursts, now and then a long run with none
        if (sender_calm > 0)
            sender_calm--;
        else if (idling_on)
        begin
            case ($urandom_range(0, 11))
                0:
                begin
                    gap = $urandom_range(1, 14);
                    @(negedge clk);
                    push <= 1'b0;
                    repeat (gap - 1)
                        @(negedge clk);
                end
                1:       sender_calm = $urandom_range(20, 80);
                default: ;
            endcase
        end
    endtask

    // frame of address byte, four data bytes and check byte, the check good or spoilt
    task automatic send_frame(logic [7:0] code, bit good_check);
        logic [7:0] body [FRAME_LEN];
        logic [7:0] sum;
        int         k;
        sum     = '0;
        body[0] = code;
        for (k = 1; k < FRAME_LEN - 1; k++)
            body[k] = pick_byte();
        for (k = 0; k < FRAME_LEN - 1; k++)
            sum += body[k];
        body[FRAME_LEN - 1] = good_check ? ~sum : (~sum ^ 8'($urandom_range(1, 255)));
        send_link_event(rx_event(body[0], 1'b1));
        for (k = 1; k < FRAME_LEN; k++)
            send_link_event(rx_event(body[k], 1'b0));
    endtask

    task automatic send_slots(int n);
        repeat (n)
            send_link_event(slot_event());
    endtask

    // stop sending, let every owed byte come out, then let dropped items clear the pipe
    task automatic wait_link_idle();
        @(negedge clk);
        push <= 1'b0;
        while (reply_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------

    task automatic write_code_reg(reg_index_t idx, logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(idx));
        pwdata  <= {24'h000000, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_STATUS_CODE)
            status_code = value;
        else
            measure_code = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_code_reg(reg_index_t idx);
        logic [31:0] want;
        want = {24'h000000, (idx == REG_STATUS_CODE) ? status_code : measure_code};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 3'(4 * int'(idx));
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            $error("prdata: expected %08h, got %08h", want, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // new request codes, written only once the link has gone quiet, then read back
    task automatic set_request_codes(logic [7:0] s_code, logic [7:0] m_code);
        wait_link_idle();
        write_code_reg(REG_STATUS_CODE, s_code);
        write_code_reg(REG_MEASURE_CODE, m_code);
        check_code_reg(REG_STATUS_CODE);
        check_code_reg(REG_MEASURE_CODE);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // both code registers come out of reset with their default values
    task automatic test_reset_codes();
        check_code_reg(REG_STATUS_CODE);
        check_code_reg(REG_MEASURE_CODE);
    endtask

    // ignored items, then a measurement reply cut short by a status request
    task automatic test_reply_switch();
        link_event_t e;
        // slot with nothing armed, data with no frame open, unknown address
        send_link_event(slot_event());
        send_link_event(rx_event(8'h5A, 1'b0));
        send_link_event(rx_event(8'hFF, 1'b1));
        send_frame(measure_code, 1'b1);
        // largest raw voltage and current at the slot that fills the buffer
        e     = slot_event();
        e.vac = 16'hFFFF;
        e.iac = 16'hFFFF;
        send_link_event(e);
        send_slots(1);
        // status frame completes mid-reply: kind flips, the byte index carries on
        send_frame(status_code, 1'b1);
        send_slots(4);
    endtask

    // both kinds open at completion: the frame is dropped and nothing is armed
    task automatic test_mixed_kinds();
        send_link_event(rx_event(status_code, 1'b1));
        send_frame(measure_code, 1'b1);
        send_slots(1);
    endtask

    // equal codes at the low extreme: the status kind wins, full fault word and state
    task automatic test_equal_codes();
        link_event_t e;
        set_request_codes(8'h00, 8'h00);
        send_frame(8'h00, 1'b1);
        e       = slot_event();
        e.fault = 16'hFFFF;
        e.state = 8'hFF;
        send_link_event(e);
        send_slots(5);
    endtask

    // mostly well-formed requests with random content, the rest broken frames and noise
    task automatic run_traffic(int budget, bit with_pause);
        int done;
        int n;
        int pause_at;
        done     = 0;
        pause_at = with_pause ? budget / 2 : -1;
        while (done < budget)
        begin
            if (pause_at >= 0 && done >= pause_at)
            begin
                // hold the sender until every owed reply byte has drained
                wait_link_idle();
                pause_at = -1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    send_frame($urandom_range(0, 1) ? status_code : measure_code,
                               $urandom_range(0, 7) != 0);
                    n = $urandom_range(0, 8);
                    send_slots(n);
                    done += FRAME_LEN + n;
                end
                6:
                begin
                    // truncated frame, later restarted or mixed with another kind
                    n = $urandom_range(0, FRAME_LEN - 2);
                    send_link_event(rx_event($urandom_range(0, 1) ? status_code : measure_code,
                                             1'b1));
                    repeat (n)
                        send_link_event(rx_event(pick_byte(), 1'b0));
                    done += n + 1;
                end
                7:
                begin
                    n = $urandom_range(1, 6);
                    send_slots(n);
                    done += n;
                end
                8:
                    // noise, mostly ignored by the link and so not counted
                    send_link_event(random_event());
                default:
                begin
                    // a stray address of the other kind ahead of a full frame
                    send_link_event(rx_event(measure_code, 1'b1));
                    send_frame(status_code, 1'b1);
                    send_slots(2);
                    done += FRAME_LEN + 3;
                end
            endcase
        end
    endtask

    // random traffic under several code settings, the register extremes among them
    task automatic test_random_traffic();
        run_traffic(300, 1'b0);
        set_request_codes(8'h00, 8'hFF);
        run_traffic(300, 1'b1);
        set_request_codes(8'hFF, 8'h00);
        run_traffic(300, 1'b0);
        set_request_codes(8'($urandom), 8'($urandom));
        run_traffic(300, 1'b0);
    endtask

    // last stretch back at the default codes with both sides running flat out
    task automatic test_full_rate();
        set_request_codes(STATUS_CODE_RESET, MEASURE_CODE_RESET);
        idling_on = 1'b0;
        run_traffic(350, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // pop with random stall bursts while idling is on, steady pop otherwise
    initial
    begin : pop_driver
        int gap;
        int calm;
        calm = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (calm > 0)
            begin
                calm--;
                @(negedge clk);
                pop <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 14);
                @(negedge clk);
                pop <= 1'b0;
                repeat (gap - 1)
                    @(negedge clk);
            end
            else
            begin
                if ($urandom_range(0, 30) == 0)
                    calm = $urandom_range(20, 80);
                @(negedge clk);
                pop <= 1'b1;
            end
        end
    end

    // every popped reply byte against the oldest one owed
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (reply_bytes_due.size() == 0)
            begin
                $error("result item with none expected: tx_byte %02h", tx_byte);
                error_count++;
            end
            else
            begin
                want = reply_bytes_due.pop_front();
                if (tx_byte !== want.tx_byte)
                begin
                    $error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_byte);
                    error_count++;
                end
                if (tx_is_address !== want.tx_is_address)
                begin
                    $error("tx_is_address: expected %0b, got %0b",
                           want.tx_is_address, tx_is_address);
                    error_count++;
                end
                if (tx_last !== want.tx_last)
                begin
                    $error("tx_last: expected %0b, got %0b", want.tx_last, tx_last);
                    error_count++;
                end
            end
        end
    end

    // hang detector: no item moving on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // sequence of tests
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        command       = CMD_RX_BYTE;
        rx_byte       = '0;
        rx_is_address = 1'b0;
        fault_flags   = '0;
        pfc_state     = '0;
        vac_rms_raw   = '0;
        iac_rms_raw   = '0;
        pop           = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        quiet_cycles  = 0;
        sender_calm   = 0;
        idling_on     = 1'b1;
        reset_link_model();
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_codes();
        test_reply_switch();
        test_mixed_kinds();
        test_equal_codes();
        test_random_traffic();
        test_full_rate();

        wait_link_idle();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== framed_request_reply_link.f =====
hdl/flink_pkg.sv
hdl/flink_front.sv
hdl/flink_queue.sv
hdl/flink_back.sv
hdl/framed_request_reply_link.sv
hdl/flink_checker.sv
test/framed_request_reply_link_tb.sv
